FILE: rtl/core/cfa_pkg.sv
//------------------------------------------------------------------------------
// cfa_pkg
// Shared constants, types and the CORDIC angle table for the attitude filter.
//------------------------------------------------------------------------------
package cfa_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [15:0] TIME_STEP_RST    = 16'd655;

  localparam logic CFG_BLEND_WEIGHT = 1'b0;
  localparam logic CFG_TIME_STEP    = 1'b1;

  // angles in Q.16 degrees; 180 deg fits in 25 bits signed, sums in 26
  localparam int ZW = 26;
  // CORDIC data path: |x|,|y| < 2^25 scaled by 2^14, growth under 1.65
  localparam int CW = 42;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ROLL,
    ST_PITCH,
    ST_BLEND,
    ST_OUT
  } state_t;

  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(2949120);
      5'd1:  r = ZW'(1740967);
      5'd2:  r = ZW'(919879);
      5'd3:  r = ZW'(466945);
      5'd4:  r = ZW'(234379);
      5'd5:  r = ZW'(117304);
      5'd6:  r = ZW'(58666);
      5'd7:  r = ZW'(29335);
      5'd8:  r = ZW'(14668);
      5'd9:  r = ZW'(7334);
      5'd10: r = ZW'(3667);
      5'd11: r = ZW'(1833);
      5'd12: r = ZW'(917);
      5'd13: r = ZW'(458);
      5'd14: r = ZW'(229);
      5'd15: r = ZW'(115);
      5'd16: r = ZW'(57);
      5'd17: r = ZW'(29);
      5'd18: r = ZW'(14);
      5'd19: r = ZW'(7);
      5'd20: r = ZW'(4);
      5'd21: r = ZW'(2);
      5'd22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/cfa_isqrt.sv
//------------------------------------------------------------------------------
// cfa_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
//------------------------------------------------------------------------------
module cfa_isqrt (
  input  logic        clk,
  input  logic        start,
  input  logic [47:0] radicand,
  output logic        done,
  output logic [23:0] root
);

  logic [47:0] rem_v;
  logic [49:0] acc;
  logic [23:0] q;
  logic [4:0]  cnt;
  logic        busy;
  logic [49:0] trial;
  logic [49:0] shifted;

  assign shifted = {acc[47:0], rem_v[47:46]};
  assign trial   = {24'd0, q, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      rem_v <= radicand;
      acc   <= '0;
      q     <= '0;
      cnt   <= 5'd0;
      busy  <= 1'b1;
    end else if (busy) begin
      rem_v <= {rem_v[45:0], 2'b00};
      if (shifted >= trial) begin
        acc <= shifted - trial;
        q   <= {q[22:0], 1'b1};
      end else begin
        acc <= shifted;
        q   <= {q[22:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd23) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = q;

endmodule

FILE: rtl/core/cfa_cordic.sv
//------------------------------------------------------------------------------
// cfa_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
//------------------------------------------------------------------------------
module cfa_cordic #(
  parameter int CORDIC_STEPS = cfa_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        start,
  input  logic signed [25:0] xin,
  input  logic signed [25:0] yin,
  output logic        done,
  output logic signed [23:0] angle
);

  localparam int CW = cfa_pkg::CW;
  localparam int ZW = cfa_pkg::ZW;

  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [4:0] i;
  logic       busy;
  logic signed [CW-1:0] xs, ys;
  logic signed [CW-1:0] xi, yi;
  logic signed [ZW-1:0] a;
  logic signed [ZW-1:0] zr;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign a  = $signed(cfa_pkg::atan_q16(i));
  assign xi = CW'(xin) <<< 14;
  assign yi = CW'(yin) <<< 14;
  assign zr = z + ZW'(128);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      i <= 5'd0;
      if (xin == 0 && yin == 0) begin
        x <= '0; y <= '0; z <= '0;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        busy <= 1'b1;
        if (xin < 0) begin
          x <= -xi;
          y <= -yi;
          z <= (yin >= 0) ? ZW'(180 * 65536) : -ZW'(180 * 65536);
        end else begin
          x <= xi;
          y <= yi;
          z <= '0;
        end
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end
      i <= i + 5'd1;
      if (32'(i) == CORDIC_STEPS - 1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign angle = 24'(zr >>> 8);

endmodule

FILE: rtl/core/cfa_mac.sv
//------------------------------------------------------------------------------
// cfa_mac
// Bit-serial signed multiplier: 16-bit unsigned by signed operand, 1 bit/cycle.
//------------------------------------------------------------------------------
module cfa_mac (
  input  logic        clk,
  input  logic        start,
  input  logic [15:0] mul_u,
  input  logic signed [32:0] mul_s,
  output logic        done,
  output logic signed [49:0] prod
);

  logic [15:0] m;
  logic signed [49:0] addend;
  logic [4:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      m      <= mul_u;
      addend <= 50'(mul_s);
      prod   <= '0;
      cnt    <= '0;
      busy   <= 1'b1;
    end else if (busy) begin
      if (m[0]) prod <= prod + addend;
      m      <= m >> 1;
      addend <= addend <<< 1;
      cnt    <= cnt + 5'd1;
      if (cnt == 5'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/complementary_filter_attitude.sv
//------------------------------------------------------------------------------
// complementary_filter_attitude
// Roll/pitch/yaw complementary filter for one IMU sample per transaction.
//------------------------------------------------------------------------------
// Input stream s_axis carries one IMU sample per transaction; the output
// stream m_axis carries roll, pitch and yaw for that sample. Exactly one
// result per input, in order.
// Items are processed one at a time. After the accept come the square root,
// then roll and pitch vectoring on the shared CORDIC (each skipped when both
// operands are zero), then seven bit-serial multiplies whose results fill the
// result register. The next sample is accepted only once that result has been
// taken. The serial multiplier and the shared CORDIC set the time per sample.
// The result sits in an output register; s_axis_tready stays low until
// it is taken, so a stalled receiver simply holds the block.
// Reset (rst, synchronous) zeroes the estimates and yaw, loads blend_weight
// = 64225 and time_step = 655. The user writes configuration with cfg_we /
// cfg_addr / cfg_wdata only while idle (unchecked); indexes above 1 are ignored.
//------------------------------------------------------------------------------
module complementary_filter_attitude #(
  parameter int CORDIC_STEPS = cfa_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x_rate, gyro_y_rate, gyro_z_rate
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_deg, pitch_deg, yaw_deg
  output logic [79:0]  m_axis_tdata
);

  cfa_pkg::state_t state, state_next;

  logic [15:0] blend_weight, time_step;
  logic signed [23:0] roll_est, pitch_est;
  logic [31:0] yaw_acc;

  logic signed [15:0] ax, ay, az;
  logic signed [19:0] gx, gy, gz;
  logic signed [23:0] roll_meas, pitch_meas;
  logic signed [24:0] dx, dy;

  logic [3:0] mstep;
  logic       sq_start, sq_done, co_start, co_done, mu_start, mu_done;
  logic [23:0] mag;
  logic signed [23:0] co_angle;
  logic signed [25:0] co_x, co_y;
  logic [15:0] mu_u;
  logic signed [32:0] mu_s;
  logic signed [49:0] mu_p, part;
  logic [47:0] sq_in;
  logic [32:0] sum_sq;

  // square root starts on the accept edge, so it takes the sample straight from the bus
  assign sum_sq =
    33'($unsigned(32'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16])))) +
    33'($unsigned(32'($signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]))));
  assign sq_in  = {sum_sq[31:0], 16'd0};

  cfa_isqrt u_sqrt (
    .clk, .start(sq_start), .radicand(sq_in), .done(sq_done), .root(mag)
  );

  cfa_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .start(co_start), .xin(co_x), .yin(co_y), .done(co_done),
    .angle(co_angle)
  );

  cfa_mac u_mac (
    .clk, .start(mu_start), .mul_u(mu_u), .mul_s(mu_s), .done(mu_done),
    .prod(mu_p)
  );

  // pitch vectoring is started from ST_ROLL
  assign co_x = (state == cfa_pkg::ST_ROLL) ? 26'($signed({1'b0, mag})) : 26'(az);
  assign co_y = (state == cfa_pkg::ST_ROLL) ? -(26'(ax) <<< 8) : 26'(ay);

  // multiply schedule
  logic [15:0] gw;
  logic [16:0] gc;
  assign gw = blend_weight;
  assign gc = 17'd65536 - 17'(gw);

  always_comb begin
    mu_u = time_step;
    mu_s = '0;
    case (mstep)
      4'd0: begin mu_u = time_step; mu_s = 33'(gx); end
      4'd1: begin mu_u = time_step; mu_s = 33'(gy); end
      4'd2: begin mu_u = time_step; mu_s = 33'(gz); end
      4'd3: begin mu_u = gw; mu_s = 33'(roll_est) + 33'(dx); end
      4'd4: begin mu_u = gc[15:0]; mu_s = 33'(roll_meas); end
      4'd5: begin mu_u = gw; mu_s = 33'(pitch_est) + 33'(dy); end
      4'd6: begin mu_u = gc[15:0]; mu_s = 33'(pitch_meas); end
      default: ;
    endcase
  end

  logic signed [49:0] rs16;
  logic signed [49:0] gcp;
  logic signed [23:0] sat;
  // gc == 65536 (weight zero): low 16 bits multiply by 0, add acc << 16
  assign gcp  = gc[16] ? (50'((mstep == 4'd6) ? pitch_meas : roll_meas) <<< 16) : '0;
  assign rs16 = (part + mu_p + gcp + 50'sd32768) >>> 16;
  always_comb begin
    if (rs16 > 50'sd8388607) sat = 24'sh7FFFFF;
    else if (rs16 < -50'sd8388608) sat = -24'sh800000;
    else sat = rs16[23:0];
  end
  logic signed [49:0] dround;
  assign dround = (mu_p + 50'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) state <= cfa_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    sq_start = 1'b0;
    co_start = 1'b0;
    case (state)
      cfa_pkg::ST_IDLE:  if (s_axis_tvalid) state_next = cfa_pkg::ST_SQRT;
      cfa_pkg::ST_SQRT:  if (sq_done) begin
        state_next = cfa_pkg::ST_ROLL;
        co_start = 1'b1;
      end
      cfa_pkg::ST_ROLL:  if (co_done) begin
        state_next = cfa_pkg::ST_PITCH;
        co_start = 1'b1;
      end
      cfa_pkg::ST_PITCH: if (co_done) state_next = cfa_pkg::ST_BLEND;
      cfa_pkg::ST_BLEND: if (mu_done && mstep == 4'd6) state_next = cfa_pkg::ST_OUT;
      cfa_pkg::ST_OUT:   if (m_axis_tready) state_next = cfa_pkg::ST_IDLE;
      default: state_next = cfa_pkg::ST_IDLE;
    endcase
    if (state == cfa_pkg::ST_IDLE && s_axis_tvalid) sq_start = 1'b1;
  end

  assign s_axis_tready = (state == cfa_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == cfa_pkg::ST_OUT);
  assign m_axis_tdata  = {yaw_acc, pitch_est, roll_est};

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= cfa_pkg::BLEND_WEIGHT_RST;
      time_step    <= cfa_pkg::TIME_STEP_RST;
      roll_est     <= '0;
      pitch_est    <= '0;
      yaw_acc      <= '0;
      mu_start     <= 1'b0;
      mstep        <= '0;
    end else begin
      mu_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          cfa_pkg::CFG_BLEND_WEIGHT: blend_weight <= cfg_wdata;
          cfa_pkg::CFG_TIME_STEP:    time_step    <= cfg_wdata;
          default: ;
        endcase
      end
      if (state == cfa_pkg::ST_IDLE && s_axis_tvalid) begin
        ax <= s_axis_tdata[15:0];
        ay <= s_axis_tdata[31:16];
        az <= s_axis_tdata[47:32];
        gx <= s_axis_tdata[67:48];
        gy <= s_axis_tdata[87:68];
        gz <= s_axis_tdata[107:88];
      end
      if (state == cfa_pkg::ST_ROLL && co_done) roll_meas <= co_angle;
      if (state == cfa_pkg::ST_PITCH && co_done) begin
        pitch_meas <= co_angle;
        mstep      <= 4'd0;
        mu_start   <= 1'b1;
      end
      if (state == cfa_pkg::ST_BLEND && mu_done) begin
        case (mstep)
          4'd0: dx <= 25'(dround);
          4'd1: dy <= 25'(dround);
          4'd2: yaw_acc <= yaw_acc + 32'(dround);
          4'd3: part <= mu_p;
          4'd4: roll_est <= sat;
          4'd5: part <= mu_p;
          4'd6: pitch_est <= sat;
          default: ;
        endcase
        if (mstep != 4'd6) begin
          mstep    <= mstep + 4'd1;
          mu_start <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/cfa_checker.sv
//------------------------------------------------------------------------------
// cfa_checker
// Port-level checks for the attitude filter, bound to the top level.
//------------------------------------------------------------------------------
module cfa_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input open while result pending");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("no processing gap after accept");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");

endmodule

bind complementary_filter_attitude cfa_checker u_cfa_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the roll/pitch/yaw complementary filter. A directed
// table of IMU samples is followed by random samples under several blend and
// time-step settings. Every result is compared with a bit-exact attitude
// predictor or typed row value, with random gaps and stalls on both streams.
//------------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT = 1_500_000;
  localparam int STEPS = 16;
  localparam int PER_PHASE = 142;

  typedef struct packed {
    logic signed [19:0] gz;
    logic signed [19:0] gy;
    logic signed [19:0] gx;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] yaw;
    logic signed [23:0] pitch;
    logic signed [23:0] roll;
  } attitude_t;

  typedef struct {
    sample_t   s;
    bit        typed;
    attitude_t r;
  } row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [0:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [79:0]  m_axis_tdata;

  complementary_filter_attitude dut (.*);

  always #5 clk = ~clk;

  // predictor state
  longint    weight_q16, step_q16, roll_est, pitch_est;
  logic [31:0] yaw_acc;
  attitude_t expected_att[$];
  bit        typed_q[$];
  attitude_t typed_val_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 0;
  int        out_stall = 0;

  const longint ATAN_Q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint root_q8(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint angle_q8(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 16384;
    y *= 16384;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z -= ATAN_Q16[i];
      end
    end
    return rnd_shift(z, 8);
  endfunction

  function automatic longint blend_angle(longint acc, longint est, longint d);
    return sat24(rnd_shift((65536 - weight_q16) * acc + weight_q16 * (est + d), 16));
  endfunction

  function automatic attitude_t predict_attitude(sample_t s);
    longint ax, ay, az, mag, dz;
    attitude_t r;
    ax = s.ax; ay = s.ay; az = s.az;
    mag = root_q8(longint'(ay * ay + az * az) << 16);
    dz = rnd_shift(step_q16 * longint'(s.gz), 16);
    roll_est = blend_angle(angle_q8(az, ay), roll_est,
                           rnd_shift(step_q16 * longint'(s.gx), 16));
    pitch_est = blend_angle(angle_q8(mag, -ax * 256), pitch_est,
                            rnd_shift(step_q16 * longint'(s.gy), 16));
    yaw_acc = yaw_acc + 32'(dz);
    r.roll = 24'(roll_est);
    r.pitch = 24'(pitch_est);
    r.yaw = yaw_acc;
    return r;
  endfunction

  function automatic int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rand20();
    case ($urandom_range(0, 7))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'h00000;
      3: return 20'($signed($urandom_range(0, 20000)) - 10000);
      default: return 20'($urandom);
    endcase
  endfunction

  // monitors: config, input and output transactions
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && cfg_we) begin
      if (cfg_addr == cfa_pkg::CFG_BLEND_WEIGHT) weight_q16 = cfg_wdata;
      else if (cfg_addr == cfa_pkg::CFG_TIME_STEP) step_q16 = cfg_wdata;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      attitude_t p;
      p = predict_attitude(sample_t'(s_axis_tdata[107:0]));
      if (typed_q.pop_front()) p = typed_val_q.pop_front();
      else void'(typed_val_q.pop_front());
      expected_att.push_back(p);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      attitude_t got, want;
      got = m_axis_tdata;
      if (expected_att.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_att.pop_front();
        if (got.roll !== want.roll || got.pitch !== want.pitch || got.yaw !== want.yaw) begin
          errors++;
          if (errors <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready <= 0;
    end else begin
      out_stall <= gap_len();
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(sample_t s, bit typed, attitude_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    typed_q.push_back(typed);
    typed_val_q.push_back(r);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, s};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] w, logic [15:0] h);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (expected_att.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= cfa_pkg::CFG_BLEND_WEIGHT;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= cfa_pkg::CFG_TIME_STEP;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic row_t mk(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                              logic [19:0] gx, logic [19:0] gy, logic [19:0] gz);
    row_t t;
    t.s = '{gz: gz, gy: gy, gx: gx, az: az, ay: ay, ax: ax};
    t.typed = 0;
    t.r = '0;
    return t;
  endfunction

  row_t table_rows[$];

  initial begin
    sample_t s;
    row_t t;
    logic [15:0] w_set[8];
    logic [15:0] h_set[8];
    weight_q16 = cfa_pkg::BLEND_WEIGHT_RST;
    step_q16 = cfa_pkg::TIME_STEP_RST;
    roll_est = 0;
    pitch_est = 0;
    yaw_acc = 0;

    // zero sample straight after reset gives a zero attitude
    t = mk(0, 0, 0, 0, 0, 0);
    t.typed = 1;
    table_rows.push_back(t);
    table_rows.push_back(mk(16'h8000, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(16'h7FFF, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(0, 0, 16'h7FFF, 0, 0, 0));
    table_rows.push_back(mk(0, 0, 16'h8000, 0, 0, 0));
    table_rows.push_back(mk(0, 16'd100, 16'h8000, 0, 0, 0));
    table_rows.push_back(mk(0, 16'hFF9C, 16'h8000, 0, 0, 0));
    table_rows.push_back(mk(0, 16'h7FFF, 0, 0, 0, 0));
    table_rows.push_back(mk(0, 16'h8000, 0, 0, 0, 0));
    table_rows.push_back(mk(16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
    table_rows.push_back(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0));
    table_rows.push_back(mk(0, 0, 16'd16384, 20'h7FFFF, 0, 0));
    table_rows.push_back(mk(0, 0, 16'd16384, 20'h80000, 0, 0));
    table_rows.push_back(mk(0, 0, 16'd16384, 0, 20'h7FFFF, 0));
    table_rows.push_back(mk(0, 0, 16'd16384, 0, 20'h80000, 0));
    table_rows.push_back(mk(0, 0, 16'd16384, 0, 0, 20'h7FFFF));
    table_rows.push_back(mk(0, 0, 16'd16384, 0, 0, 20'h80000));
    table_rows.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
    table_rows.push_back(mk(16'd1, 16'd1, 16'd1, 20'd1, 20'd1, 20'd1));
    table_rows.push_back(mk(16'd200, 16'hFF00, 16'd16000, 20'd2560, 20'hFF000, 20'd77));

    w_set = '{cfa_pkg::BLEND_WEIGHT_RST, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd32768,
              16'd0, 16'd0};
    h_set = '{cfa_pkg::TIME_STEP_RST, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd6554,
              16'd0, 16'd0};
    w_set[6] = 16'($urandom);
    h_set[6] = 16'($urandom);
    w_set[7] = cfa_pkg::BLEND_WEIGHT_RST;
    h_set[7] = 16'($urandom_range(1, 2000));

    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (table_rows[i]) send_sample(table_rows[i].s, table_rows[i].typed, table_rows[i].r);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) write_config(w_set[ph], h_set[ph]);
      quiet = (ph == 3);
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          // gravity-like sample with modest rates
          s.ax = 16'($signed($urandom_range(0, 32000)) - 16000);
          s.ay = 16'($signed($urandom_range(0, 32000)) - 16000);
          s.az = 16'($signed($urandom_range(0, 32000)) - 16000);
          s.gx = 20'($signed($urandom_range(0, 100000)) - 50000);
          s.gy = 20'($signed($urandom_range(0, 100000)) - 50000);
          s.gz = 20'($signed($urandom_range(0, 100000)) - 50000);
        end else begin
          s.ax = rand16(); s.ay = rand16(); s.az = rand16();
          s.gx = rand20(); s.gy = rand20(); s.gz = rand20();
        end
        send_sample(s, 0, '0);
      end
    end
    s_axis_tvalid <= 0;

    @(posedge clk);
    while (expected_att.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_att.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/cfa_pkg.sv
rtl/core/cfa_isqrt.sv
rtl/core/cfa_cordic.sv
rtl/core/cfa_mac.sv
rtl/core/complementary_filter_attitude.sv
rtl/core/cfa_checker.sv
bench/tb_top.sv
